[rtl/mlss_pkg.sv]
// Shared types and constants for the minimum-linger subflow select unit.
`default_nettype none
package mlss_pkg;

	localparam int SLOTS        = 8;
	localparam int SLOT_W       = 3;
	localparam int QUEUED_W     = 31;
	localparam int RATE_W       = 32;
	localparam int TIME_W       = 64;
	localparam int LINGER_SHIFT = 32;
	localparam int DIV_STEPS    = TIME_W;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

	localparam logic [TIME_W-1:0] NONE_TIME = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} mlss_state_t;

	typedef struct packed {
		logic start;
	} mlss_div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mlss_div_sts_t;

endpackage
`default_nettype wire

[rtl/min_linger_subflow_select_unit.sv]
// Minimum-linger subflow select: per-slot linger divide and running minimum.
// Steps: a qualifying item is accepted, divided bit-serially by mlss_div and folded
// into the running minimum; a skipped item is only accepted. After a last item the finish
// step loads the result once the output is free. No new item is taken while a divide runs.
// Reset: arst_n clears the sequencer, divider control, output valid and the
// running minimum (all-ones time, slot 0).
`default_nettype none
module min_linger_subflow_select_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [mlss_pkg::SLOT_W-1:0]     slot,
	input  wire logic                            metric_present,
	input  wire logic [mlss_pkg::QUEUED_W-1:0]   queued_bytes,
	input  wire logic [mlss_pkg::RATE_W-1:0]     pacing_rate,
	input  wire logic                            last_slot,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [mlss_pkg::SLOT_W-1:0]          chosen_slot,
	output logic [mlss_pkg::TIME_W-1:0]          min_linger
);
	import mlss_pkg::*;

	mlss_state_t state_q, state_d;

	logic [SLOT_W-1:0] slot_q;
	logic              last_q;
	logic [TIME_W-1:0] best_time_q;
	logic [SLOT_W-1:0] best_slot_q;
	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [TIME_W-1:0] out_time_q;

	mlss_div_ctl_t     div_ctl;
	mlss_div_sts_t     div_sts;
	logic [TIME_W-1:0] div_quo;
	logic [TIME_W-1:0] dividend;

	logic in_acc;
	logic qualifies;
	logic out_free;
	logic load_out;

	assign in_acc    = in_valid && in_ready;
	assign qualifies = metric_present && (pacing_rate != '0) && (32'(slot) < 32'(SLOTS));
	assign out_free  = !out_valid_q || out_ready;
	assign dividend  = TIME_W'(queued_bytes) << LINGER_SHIFT;

	mlss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (dividend),
		.divisor  (pacing_rate),
		.sts      (div_sts),
		.quotient (div_quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (qualifies) state_d = ST_DIV;
					else if (last_slot) state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				if (div_sts.done) state_d = last_q ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		div_ctl.start = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				div_ctl.start = in_valid && qualifies;
			end
			ST_DIV: ;
			ST_FIN: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			best_time_q <= NONE_TIME;
			best_slot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				// result taken, running minimum back to its idle values
				best_time_q <= NONE_TIME;
				best_slot_q <= '0;
			end else if (state_q == ST_DIV && div_sts.done && div_quo < best_time_q) begin
				best_time_q <= div_quo;
				best_slot_q <= slot_q;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			slot_q <= slot;
			last_q <= last_slot;
		end
		if (load_out) begin
			out_slot_q <= best_slot_q;
			out_time_q <= best_time_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign chosen_slot = out_slot_q;
	assign min_linger  = out_time_q;

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_sts.busy)
		else $error("input ready while divider busy");

	a_div_done_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_sts.done) |=> state_q != ST_DIV)
		else $error("sequencer stuck after divide done");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside finish step");

	a_chosen_has_time: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && chosen_slot != '0) |-> min_linger != NONE_TIME)
		else $error("chosen slot carries no-candidate time");

endmodule
`default_nettype wire

[rtl/mlss_div.sv]
// Restoring 64-by-32 unsigned divider, one quotient bit per cycle.
`default_nettype none
module mlss_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mlss_pkg::mlss_div_ctl_t       ctl,
	input  wire logic [mlss_pkg::TIME_W-1:0]   dividend,
	input  wire logic [mlss_pkg::RATE_W-1:0]   divisor,
	output mlss_pkg::mlss_div_sts_t            sts,
	output logic [mlss_pkg::TIME_W-1:0]        quotient
);
	import mlss_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [RATE_W:0]      rem_q;
	logic [TIME_W-1:0]    quo_q;
	logic [RATE_W-1:0]    dsr_q;

	logic [RATE_W:0] rem_sh;
	logic [RATE_W:0] rem_diff;
	logic            fits;

	// quo_q shifts dividend bits out at the top and quotient bits in at the bottom
	always_comb begin
		rem_sh   = {rem_q[RATE_W-1:0], quo_q[TIME_W-1]};
		fits     = rem_sh >= {1'b0, dsr_q};
		rem_diff = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !ctl.start && busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff : rem_sh;
			quo_q <= {quo_q[TIME_W-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire
